[src/csp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants for the CIGAR stream parser.
// ----------------------------------------------------------------------------
package csp_pkg;

  // Cursor widths
  localparam int READ_BITS = 24;
  localparam int REF_BITS  = 32;

  localparam logic [READ_BITS-1:0] READ_MAX = {READ_BITS{1'b1}};

  // ASCII codes of interest
  localparam logic [7:0] CH_STAR = 8'h2A;  // '*'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'
  localparam logic [7:0] CH_EQ   = 8'h3D;  // '='
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_X    = 8'h58;

  // Segment operation codes as seen by the consumer
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_M    = 4'd1,
    OP_EQ   = 4'd2,
    OP_X    = 4'd3,
    OP_I    = 4'd4,
    OP_D    = 4'd5,
    OP_N    = 4'd6,
    OP_S    = 4'd7,
    OP_H    = 4'd8,
    OP_ERR  = 4'd9
  } csp_op_t;

  // Character classes
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DIGIT,
    CLS_STAR,
    CLS_PAD,
    CLS_OP
  } csp_cls_t;

  // Decoded character
  typedef struct packed {
    csp_cls_t    cls;
    logic [3:0]  digit;
    csp_op_t     op;
    logic        mv_read;
    logic        mv_ref;
  } csp_dec_t;

  // One segment record
  typedef struct packed {
    csp_op_t                op;
    logic                   read_valid;
    logic [READ_BITS-1:0]   read_start;
    logic [READ_BITS-1:0]   read_end;
    logic                   ref_valid;
    logic [REF_BITS-1:0]    ref_start;
    logic [REF_BITS-1:0]    ref_end;
    logic [READ_BITS-1:0]   read_total;
    logic                   clear_previous;
  } csp_rec_t;

endpackage
`default_nettype wire

[src/csp_char_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csp_char_decode
// Classifies one CIGAR character: digit, star, padding, operation or other.
// ----------------------------------------------------------------------------
module csp_char_decode (
  input  wire logic [7:0]       ch,
  output csp_pkg::csp_dec_t     dec
);

  always_comb begin
    dec.cls     = csp_pkg::CLS_OTHER;
    dec.digit   = 4'd0;
    dec.op      = csp_pkg::OP_NONE;
    dec.mv_read = 1'b0;
    dec.mv_ref  = 1'b0;

    if (ch >= csp_pkg::CH_ZERO && ch <= csp_pkg::CH_NINE) begin
      dec.cls   = csp_pkg::CLS_DIGIT;
      dec.digit = 4'(ch - csp_pkg::CH_ZERO);
    end else begin
      case (ch)
        csp_pkg::CH_STAR: dec.cls = csp_pkg::CLS_STAR;
        csp_pkg::CH_P:    dec.cls = csp_pkg::CLS_PAD;
        csp_pkg::CH_M: begin
          dec.cls = csp_pkg::CLS_OP; dec.op = csp_pkg::OP_M;
          dec.mv_read = 1'b1; dec.mv_ref = 1'b1;
        end
        csp_pkg::CH_EQ: begin
          dec.cls = csp_pkg::CLS_OP; dec.op = csp_pkg::OP_EQ;
          dec.mv_read = 1'b1; dec.mv_ref = 1'b1;
        end
        csp_pkg::CH_X: begin
          dec.cls = csp_pkg::CLS_OP; dec.op = csp_pkg::OP_X;
          dec.mv_read = 1'b1; dec.mv_ref = 1'b1;
        end
        csp_pkg::CH_I: begin
          dec.cls = csp_pkg::CLS_OP; dec.op = csp_pkg::OP_I; dec.mv_read = 1'b1;
        end
        csp_pkg::CH_S: begin
          dec.cls = csp_pkg::CLS_OP; dec.op = csp_pkg::OP_S; dec.mv_read = 1'b1;
        end
        // hard clips still count on the read here
        csp_pkg::CH_H: begin
          dec.cls = csp_pkg::CLS_OP; dec.op = csp_pkg::OP_H; dec.mv_read = 1'b1;
        end
        csp_pkg::CH_D: begin
          dec.cls = csp_pkg::CLS_OP; dec.op = csp_pkg::OP_D; dec.mv_ref = 1'b1;
        end
        csp_pkg::CH_N: begin
          dec.cls = csp_pkg::CLS_OP; dec.op = csp_pkg::OP_N; dec.mv_ref = 1'b1;
        end
        default: dec.cls = csp_pkg::CLS_OTHER;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/csp_seg_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csp_seg_engine
// Parser state (length, cursors, stop flag) and the segment record logic.
// State advances by one character per cycle when adv is high.
// ----------------------------------------------------------------------------
module csp_seg_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire csp_pkg::csp_dec_t             dec,
  input  wire logic                          start_of_string,
  input  wire logic [csp_pkg::REF_BITS-1:0]  ref_origin,
  output logic                               has_result,
  output csp_pkg::csp_rec_t                  rec
);

  localparam int RB = csp_pkg::READ_BITS;
  localparam int FB = csp_pkg::REF_BITS;

  logic [RB-1:0] length_acc, length_acc_next;
  logic          digits_seen, digits_seen_next;
  logic [RB-1:0] read_cursor, read_cursor_next;   // also the read total so far
  logic [FB-1:0] ref_cursor, ref_cursor_next;
  logic          stopped, stopped_next;

  // state as seen after an optional start-of-string clear
  logic [RB-1:0] acc_eff;
  logic          dig_eff;
  logic [RB-1:0] rc_eff;
  logic [FB-1:0] fc_eff;
  logic          stop_eff;

  logic [RB+3:0] acc_mul;
  logic [RB:0]   read_sum;
  logic [RB:0]   read_last;
  logic [FB-1:0] ref_sum;
  logic          len_nz;

  always_comb begin
    acc_eff  = start_of_string ? '0 : length_acc;
    dig_eff  = start_of_string ? 1'b0 : digits_seen;
    rc_eff   = start_of_string ? '0 : read_cursor;
    fc_eff   = start_of_string ? ref_origin : ref_cursor;
    stop_eff = start_of_string ? 1'b0 : stopped;
  end

  // decimal accumulate: acc*10 + digit
  assign acc_mul = ({4'd0, acc_eff} << 3) + ({4'd0, acc_eff} << 1) + {{RB{1'b0}}, dec.digit};

  // cursor arithmetic
  assign read_sum  = {1'b0, rc_eff} + {1'b0, acc_eff};
  assign read_last = read_sum - {{RB{1'b0}}, 1'b1};
  assign ref_sum   = fc_eff + FB'(acc_eff);
  assign len_nz    = (acc_eff != '0);

  // next state and record
  always_comb begin
    length_acc_next  = acc_eff;
    digits_seen_next = dig_eff;
    read_cursor_next = rc_eff;
    ref_cursor_next  = fc_eff;
    stopped_next     = stop_eff;
    has_result       = 1'b0;

    rec                = '0;
    rec.op             = csp_pkg::OP_NONE;
    rec.read_total     = rc_eff;

    if (!stop_eff) begin
      case (dec.cls)
        csp_pkg::CLS_DIGIT: begin
          length_acc_next  = (acc_mul[RB+3:RB] != 4'd0) ? csp_pkg::READ_MAX : acc_mul[RB-1:0];
          digits_seen_next = 1'b1;
        end
        csp_pkg::CLS_STAR: begin
          stopped_next       = 1'b1;
          length_acc_next    = '0;
          digits_seen_next   = 1'b0;
          has_result         = 1'b1;
          rec.clear_previous = 1'b1;
        end
        csp_pkg::CLS_PAD: begin
          length_acc_next  = '0;
          digits_seen_next = 1'b0;
        end
        csp_pkg::CLS_OP: begin
          has_result = 1'b1;
          if (!dig_eff) begin
            rec.op = csp_pkg::OP_ERR;
          end else begin
            rec.op           = dec.op;
            length_acc_next  = '0;
            digits_seen_next = 1'b0;
            if (dec.mv_read && len_nz) begin
              rec.read_valid   = 1'b1;
              rec.read_start   = rc_eff;
              rec.read_end     = read_last[RB] ? csp_pkg::READ_MAX : read_last[RB-1:0];
              read_cursor_next = read_sum[RB] ? csp_pkg::READ_MAX : read_sum[RB-1:0];
              rec.read_total   = read_cursor_next;
            end
            if (dec.mv_ref && len_nz) begin
              rec.ref_valid   = 1'b1;
              rec.ref_start   = fc_eff;
              rec.ref_end     = ref_sum - {{(FB-1){1'b0}}, 1'b1};
              ref_cursor_next = ref_sum;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length_acc  <= '0;
      digits_seen <= 1'b0;
      read_cursor <= '0;
      ref_cursor  <= '0;
      stopped     <= 1'b0;
    end else if (adv) begin
      length_acc  <= length_acc_next;
      digits_seen <= digits_seen_next;
      read_cursor <= read_cursor_next;
      ref_cursor  <= ref_cursor_next;
      stopped     <= stopped_next;
    end
  end

endmodule
`default_nettype wire

[src/cigar_stream_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cigar_stream_parser
// Turns a CIGAR string, one character per transaction, into segment records.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per transaction; tuser flags the first
//   character of a string, which clears the parser and loads the reference
//   origin from tdata before the character itself is handled.
//   m_axis carries one segment record for each operation letter, an error
//   record for a letter with no length, and a clear record for '*'.
//   Digits, 'P', unknown characters and anything after a '*' give no record.
// Timing:
//   A character is captured in the input register and its record is then
//   registered in the output register. One character per cycle is
//   sustained while the output is not stalled; the limit is the update of
//   the length accumulator and cursors in the segment engine.
// Reset clears the valid flags of both registers and all parser state.
// When m_axis_tready is low the record is held; the input register still
// takes one more character, and characters that give no record keep flowing.
// ----------------------------------------------------------------------------
module cigar_stream_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [39:0]   s_axis_tdata,   // [7:0] ch, [39:8] ref_origin
  input  wire logic          s_axis_tuser,   // [0] start_of_string
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [0] read_valid, [24:1] read_start, [48:25] read_end, [49] ref_valid,
  // [81:50] ref_start, [113:82] ref_end, [137:114] read_total, [143:138] zero
  output logic [143:0]       m_axis_tdata,
  output logic [4:0]         m_axis_tuser    // [3:0] op_code, [4] clear_previous
);

  // input register
  logic        in_vld;
  logic [7:0]  in_ch;
  logic        in_start;
  logic [31:0] in_origin;

  // output register
  logic              out_vld;
  csp_pkg::csp_rec_t out_rec;

  logic              adv;
  logic              has_result;
  csp_pkg::csp_rec_t rec;
  csp_pkg::csp_dec_t dec;

  // the held character moves on unless a pending record blocks it
  assign adv           = in_vld && (!has_result || !out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch     <= s_axis_tdata[7:0];
      in_origin <= s_axis_tdata[39:8];
      in_start  <= s_axis_tuser;
    end
  end

  csp_char_decode u_decode (
    .ch  (in_ch),
    .dec (dec)
  );

  csp_seg_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .dec             (dec),
    .start_of_string (in_start),
    .ref_origin      (csp_pkg::REF_BITS'(in_origin)),
    .has_result      (has_result),
    .rec             (rec)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv && has_result) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      out_rec <= rec;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {6'd0,
                          out_rec.read_total[23:0],
                          out_rec.ref_end[31:0],
                          out_rec.ref_start[31:0],
                          out_rec.ref_valid,
                          out_rec.read_end[23:0],
                          out_rec.read_start[23:0],
                          out_rec.read_valid};
  assign m_axis_tuser  = {out_rec.clear_previous, out_rec.op};

`ifndef SYNTHESIS
  // a produced record always lands in the output register
  a_rec_loaded: assert property (@(posedge clk) disable iff (rst)
    (adv && has_result) |=> m_axis_tvalid)
    else $error("record lost on its way to the output register");

  // ready only drops while a character is held
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_vld)
    else $error("input stalled with an empty input register");

  // error and clear records never carry spans
  a_no_span: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_rec.op == csp_pkg::OP_ERR || out_rec.clear_previous))
      |-> (!out_rec.read_valid && !out_rec.ref_valid))
    else $error("span flagged on an error or clear record");

  // saturated read spans never run backwards
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_rec.read_valid) |-> (out_rec.read_end >= out_rec.read_start))
    else $error("read end before read start");
`endif

endmodule
`default_nettype wire
